[hw/rtl/fixed_partition_fit_allocator_top_assert.svh]
// Assertion macros shared by the allocator RTL.
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_TOP_ASSERT_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, ignored while reset is asserted.
`define FPFA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, ignored while reset is asserted.
`define FPFA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define FPFA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define FPFA_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[hw/rtl/fpfa_pkg.sv]
// Shared types, codes and defaults of the fixed-partition allocator.
package fpfa_pkg;

    localparam int MAX_PARTITIONS_DEF = 16;
    localparam int SIZE_BITS_DEF      = 16;

    // Field widths of the stream payloads
    localparam int INDEX_W    = 4;
    localparam int SIZE_KB_W  = 16;
    localparam int REQ_NUM_W  = 16;
    localparam int COUNT_W    = 5;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 5;

    typedef logic [1:0] policy_t;
    localparam policy_t POL_FIRST = 2'd0;
    localparam policy_t POL_BEST  = 2'd1;
    localparam policy_t POL_WORST = 2'd2;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
    localparam cfg_addr_t REG_FIT_POLICY      = 1'd0;
    localparam cfg_addr_t REG_PARTITION_COUNT = 1'd1;

    typedef struct packed {
        logic busy;
        logic done;
        logic found;
    } scan_status_t;

endpackage

[hw/rtl/fpfa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module fpfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/fpfa_scan.sv]
// Partition scan unit: one size read per cycle, fit selection on returned data.
`include "fixed_partition_fit_allocator_top_assert.svh"

module fpfa_scan #(
    parameter int MAX_PARTITIONS = fpfa_pkg::MAX_PARTITIONS_DEF,
    parameter int SIZE_BITS      = fpfa_pkg::SIZE_BITS_DEF,
    localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1,
    localparam int LIM_W = $clog2(MAX_PARTITIONS + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  fpfa_pkg::policy_t      policy,
    input  logic [LIM_W-1:0]       limit,
    input  logic [SIZE_BITS-1:0]   req_size,
    input  logic [MAX_PARTITIONS-1:0] mark,
    output logic [IDX_W-1:0]       rd_addr,
    input  logic [SIZE_BITS-1:0]   rd_data,
    output fpfa_pkg::scan_status_t status,
    output logic [IDX_W-1:0]       pick,
    output logic [SIZE_BITS-1:0]   left
);
    import fpfa_pkg::*;

    logic [LIM_W-1:0]     issue_idx_reg, issue_idx_next;
    logic                 issuing_reg, issuing_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic                 cmp_last_reg, cmp_last_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    logic [SIZE_BITS-1:0] left_reg, left_next;
    logic                 done_reg, done_next;
    logic                 fits, better, take;
    logic [SIZE_BITS-1:0] cand_left;
    logic [LIM_W-1:0]     issue_inc;

    assign issue_inc = issue_idx_reg + LIM_W'(1);
    assign rd_addr   = issue_idx_reg[IDX_W-1:0];

    assign fits      = !mark[cmp_idx_reg] && (rd_data >= req_size);
    assign cand_left = rd_data - req_size;

    always_comb begin
        unique case (policy)
            POL_BEST:  better = cand_left < left_reg;
            POL_WORST: better = cand_left > left_reg;
            default:   better = 1'b0;
        endcase
        take = cmp_valid_reg && fits && (!found_reg || better);
    end

    always_comb begin
        issue_idx_next = issue_idx_reg;
        issuing_next   = issuing_reg;
        cmp_valid_next = 1'b0;
        cmp_last_next  = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        pick_next      = pick_reg;
        left_next      = left_reg;
        done_next      = 1'b0;
        if (start) begin
            issue_idx_next = '0;
            issuing_next   = (limit != '0);
            found_next     = 1'b0;
            pick_next      = '0;
            left_next      = '0;
            done_next      = (limit == '0);
        end else begin
            if (issuing_reg) begin
                cmp_valid_next = 1'b1;
                cmp_idx_next   = issue_idx_reg[IDX_W-1:0];
                cmp_last_next  = (issue_inc == limit);
                issue_idx_next = issue_inc;
                issuing_next   = (issue_inc != limit);
            end
            if (take) begin
                found_next = 1'b1;
                pick_next  = cmp_idx_reg;
                left_next  = cand_left;
            end
            done_next = cmp_valid_reg && cmp_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issuing_reg   <= 1'b0;
            cmp_valid_reg <= 1'b0;
            cmp_last_reg  <= 1'b0;
            done_reg      <= 1'b0;
            found_reg     <= 1'b0;
        end else begin
            issuing_reg   <= issuing_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_last_reg  <= cmp_last_next;
            done_reg      <= done_next;
            found_reg     <= found_next;
        end
        issue_idx_reg <= issue_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        pick_reg      <= pick_next;
        left_reg      <= left_next;
    end

    assign status.busy  = issuing_reg || cmp_valid_reg;
    assign status.done  = done_reg;
    assign status.found = found_reg;
    assign pick         = pick_reg;
    assign left         = left_reg;

    `FPFA_ASSERT_NXT(a_issue_feeds_compare, aclk, aresetn, issuing_reg && !start, cmp_valid_reg)
    `FPFA_ASSERT_IMP(a_done_scan_drained, aclk, aresetn, done_reg, !issuing_reg && !cmp_valid_reg)
    `FPFA_ASSERT_IMP(a_pick_within_limit, aclk, aresetn, done_reg && found_reg,
                     LIM_W'(pick_reg) < limit)

endmodule

[hw/rtl/fixed_partition_fit_allocator_top.sv]
// Fixed-partition allocator: a load is taken in the idle state and writes
// the size RAM directly. For a request the scan reads one size per cycle
// from the single read port of the size RAM, one for each partition in
// use, and compares each size in the cycle after its read; then the scan
// flags itself done, and the write-back state writes the leftover size
// back if a partition fits and loads the result register. A new item is
// taken as soon as the block returns to idle, while the previous result
// may still wait in the output register; the write-back state of the next
// request holds for as long as that result is not taken.
`include "fixed_partition_fit_allocator_top_assert.svh"

module fixed_partition_fit_allocator_top #(
    parameter int MAX_PARTITIONS = fpfa_pkg::MAX_PARTITIONS_DEF,
    parameter int SIZE_BITS      = fpfa_pkg::SIZE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [fpfa_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [fpfa_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fpfa_pkg::S_TDATA_W-1:0]  s_tdata,   // entry_index, size_kb, zero pad
    input  logic                            s_tuser,   // kind
    input  logic                            s_tlast,   // last_request
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fpfa_pkg::M_TDATA_W-1:0]  m_tdata,   // partition_index, space_left_kb,
                                                       // request_number, zero pad
    output logic                            m_tuser,   // granted
    output logic                            m_tlast    // batch_done
);
    import fpfa_pkg::*;

    localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int LIM_W = $clog2(MAX_PARTITIONS + 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_WRITE = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    policy_t               policy_reg, policy_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [MAX_PARTITIONS-1:0] mark_reg, mark_next;
    logic [REQ_NUM_W-1:0]  req_cnt_reg, req_cnt_next;
    logic [SIZE_BITS-1:0]  req_size_reg, req_size_next;
    logic                  req_last_reg, req_last_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                  m_tuser_reg, m_tuser_next;
    logic                  m_tlast_reg, m_tlast_next;

    logic                  in_xfer, out_free;
    logic [INDEX_W-1:0]    in_idx;
    logic [SIZE_KB_W-1:0]  in_size;
    logic                  load_ok;
    logic [LIM_W-1:0]      limit;
    logic                  scan_start;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr, ram_raddr;
    logic [SIZE_BITS-1:0]  ram_wdata, ram_rdata;

    scan_status_t          scan_status;
    logic [IDX_W-1:0]      scan_pick;
    logic [SIZE_BITS-1:0]  scan_left;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign in_idx   = s_tdata[INDEX_W-1:0];
    assign in_size  = s_tdata[INDEX_W +: SIZE_KB_W];
    assign load_ok  = 32'(in_idx) < MAX_PARTITIONS;
    assign out_free = !m_tvalid_reg || m_tready;

    assign limit = (32'(count_reg) > MAX_PARTITIONS) ? LIM_W'(MAX_PARTITIONS)
                                                     : LIM_W'(count_reg);
    assign scan_start = in_xfer && (s_tuser == KIND_REQUEST);

    fpfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_PARTITIONS)
    ) u_size_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fpfa_scan #(
        .MAX_PARTITIONS (MAX_PARTITIONS),
        .SIZE_BITS      (SIZE_BITS)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (scan_start),
        .policy   (policy_reg),
        .limit    (limit),
        .req_size (req_size_next),
        .mark     (mark_reg),
        .rd_addr  (ram_raddr),
        .rd_data  (ram_rdata),
        .status   (scan_status),
        .pick     (scan_pick),
        .left     (scan_left)
    );

    always_comb begin
        state_next    = state_reg;
        policy_next   = policy_reg;
        count_next    = count_reg;
        mark_next     = mark_reg;
        req_cnt_next  = req_cnt_reg;
        req_size_next = req_size_reg;
        req_last_next = req_last_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        ram_we        = 1'b0;
        ram_waddr     = scan_pick;
        ram_wdata     = scan_left;

        if (cfg_we) begin
            unique case (cfg_addr)
                REG_FIT_POLICY:      policy_next = cfg_wdata[1:0];
                REG_PARTITION_COUNT: count_next  = cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_tuser == KIND_LOAD) begin
                        // loads write straight through and clear the mark
                        if (load_ok) begin
                            ram_we    = 1'b1;
                            ram_waddr = IDX_W'(in_idx);
                            ram_wdata = SIZE_BITS'(in_size);
                            mark_next[IDX_W'(in_idx)] = 1'b0;
                        end
                    end else begin
                        req_size_next = SIZE_BITS'(in_size);
                        req_last_next = s_tlast;
                        if (req_cnt_reg != '1) begin
                            req_cnt_next = req_cnt_reg + REQ_NUM_W'(1);
                        end
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_status.done) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                // hold until the result register can take the transaction
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = scan_status.found;
                    m_tlast_next  = req_last_reg;
                    if (scan_status.found) begin
                        ram_we               = 1'b1;
                        mark_next[scan_pick] = 1'b1;
                        m_tdata_next = {4'b0, req_cnt_reg, SIZE_KB_W'(scan_left),
                                        INDEX_W'(scan_pick)};
                    end else begin
                        m_tdata_next = {4'b0, req_cnt_reg, SIZE_KB_W'(0), INDEX_W'(0)};
                    end
                    if (req_last_reg) begin
                        req_cnt_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            policy_reg   <= POL_FIRST;
            count_reg    <= '0;
            mark_reg     <= '0;
            req_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            policy_reg   <= policy_next;
            count_reg    <= count_next;
            mark_reg     <= mark_next;
            req_cnt_reg  <= req_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        req_size_reg <= req_size_next;
        req_last_reg <= req_last_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
        m_tlast_reg  <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `FPFA_ASSERT_IMP(a_done_only_in_scan, aclk, aresetn, scan_status.done, state_reg == ST_SCAN)
    `FPFA_ASSERT_IMP(a_idle_scan_quiet, aclk, aresetn, state_reg == ST_IDLE, !scan_status.busy)
    `FPFA_ASSERT_IMP(a_result_from_write, aclk, aresetn, $rose(m_tvalid_reg),
                     $past(state_reg) == ST_WRITE)
    `FPFA_ASSERT_NXT(a_grant_marks, aclk, aresetn,
                     state_reg == ST_WRITE && out_free && scan_status.found,
                     mark_reg[$past(scan_pick)])

endmodule

[verif/fixed_partition_fit_allocator_top_tb.sv]
// Self-checking testbench of the fixed-partition allocator: directed and random traffic.
module fixed_partition_fit_allocator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fpfa_pkg::*;

    localparam policy_t POL_RESERVED  = 2'd3;
    localparam int      NUM_ENTRIES   = MAX_PARTITIONS_DEF;
    localparam int      SETTLE_CYCLES = MAX_PARTITIONS_DEF + 8;
    localparam int      STUCK_LIMIT   = 2000;
    localparam int      MAX_REPORTS   = 40;

    typedef struct {
        logic                 granted;
        logic [INDEX_W-1:0]   index;
        logic [SIZE_KB_W-1:0] left;
        logic [REQ_NUM_W-1:0] number;
        logic                 done;
    } grant_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    cfg_addr_t             cfg_addr  = REG_FIT_POLICY;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = KIND_LOAD;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    // allocator shadow state
    logic [SIZE_KB_W-1:0] part_size    [NUM_ENTRIES] = '{default: '0};
    logic                 part_taken   [NUM_ENTRIES] = '{default: 1'b0};
    logic                 entry_loaded [NUM_ENTRIES] = '{default: 1'b0};
    logic [REQ_NUM_W-1:0] req_count  = '0;
    policy_t              cur_policy = POL_FIRST;
    logic [COUNT_W-1:0]   cur_count  = '0;

    grant_t pending_grants[$];

    int tx_idle_pct  = 26;
    int rx_stall_pct = 56;
    int error_count  = 0;
    int stuck_cycles = 0;

    fixed_partition_fit_allocator_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void apply_load(input logic [INDEX_W-1:0] index,
                                       input logic [SIZE_KB_W-1:0] size);
        part_size[index]    = size;
        part_taken[index]   = 1'b0;
        entry_loaded[index] = 1'b1;
    endfunction

    function automatic void allocate_request(input logic [SIZE_KB_W-1:0] size, input logic last);
        grant_t               g;
        int                   limit;
        int                   pick;
        logic                 found;
        logic [SIZE_KB_W-1:0] pick_left;
        logic [SIZE_KB_W-1:0] left;
        if (req_count != '1)
            req_count++;
        limit     = (cur_count > NUM_ENTRIES) ? NUM_ENTRIES : cur_count;
        found     = 1'b0;
        pick      = 0;
        pick_left = '0;
        for (int j = 0; j < limit; j++) begin
            if (part_taken[j] || part_size[j] < size)
                continue;
            left = part_size[j] - size;
            if (!found) begin
                found     = 1'b1;
                pick      = j;
                pick_left = left;
                // anything but best or worst fit stops at the first fit
                if (cur_policy != POL_BEST && cur_policy != POL_WORST)
                    break;
            end else if (cur_policy == POL_BEST && left < pick_left) begin
                pick      = j;
                pick_left = left;
            end else if (cur_policy == POL_WORST && left > pick_left) begin
                pick      = j;
                pick_left = left;
            end
        end
        if (found) begin
            part_size[pick]  = pick_left;
            part_taken[pick] = 1'b1;
        end
        g.granted = found;
        g.index   = found ? pick[INDEX_W-1:0] : '0;
        g.left    = found ? pick_left : '0;
        g.number  = req_count;
        g.done    = last;
        pending_grants.push_back(g);
        if (last)
            req_count = '0;
    endfunction

    function automatic void check_field(input string what, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    function automatic logic [SIZE_KB_W-1:0] random_size();
        int sel;
        sel = $urandom_range(0, 19);
        case (sel)
            0:       return '0;
            1:       return '1;
            2, 3:    return SIZE_KB_W'($urandom_range(0, 65535));
            4, 5, 6, 7, 8: begin
                // coarse steps make ties between partitions common
                return SIZE_KB_W'(100 * $urandom_range(0, 10));
            end
            default: return SIZE_KB_W'($urandom_range(0, 1000));
        endcase
    endfunction

    task automatic send_item(input logic kind, input logic [INDEX_W-1:0] index,
                             input logic [SIZE_KB_W-1:0] size, input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tlast  <= last;
        s_tdata  <= {{(S_TDATA_W - INDEX_W - SIZE_KB_W){1'b0}}, size, index};
        do @(posedge aclk); while (!s_tready);
        if (kind == KIND_LOAD)
            apply_load(index, size);
        else
            allocate_request(size, last);
    endtask

    task automatic load_entry(input logic [INDEX_W-1:0] index, input logic [SIZE_KB_W-1:0] size,
                              input logic last = 1'b0);
        send_item(KIND_LOAD, index, size, last);
    endtask

    task automatic send_request(input logic [SIZE_KB_W-1:0] size, input logic last);
        // the index field is don't-care on a request, so keep it moving
        send_item(KIND_REQUEST, INDEX_W'($urandom_range(0, 15)), size, last);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge aclk);
    endtask

    task automatic quiesce();
        wait_for_results();
        // a trailing load gives no result, so allow a full request time to settle
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input policy_t pol, input logic [COUNT_W-1:0] cnt);
        quiesce();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_FIT_POLICY;
        cfg_wdata <= CFG_DATA_W'(pol);
        @(posedge aclk);
        cfg_addr  <= REG_PARTITION_COUNT;
        cfg_wdata <= cnt;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        cur_policy  = pol;
        cur_count   = cnt;
    endtask

    task automatic test_empty_table();
        // reset state: no partitions in use, every request starves
        send_request(16'd0, 1'b0);
        load_entry(4'd15, 16'hFFFF, 1'b1);
        send_request(16'hFFFF, 1'b1);
    endtask

    task automatic test_fit_policies();
        configure(POL_FIRST, 5'd4);
        load_entry(4'd0, 16'd300);
        load_entry(4'd1, 16'd500);
        load_entry(4'd2, 16'd200);
        load_entry(4'd3, 16'd500);
        send_request(16'd150, 1'b0);
        configure(POL_BEST, 5'd4);
        load_entry(4'd0, 16'd300);
        send_request(16'd180, 1'b0);
        configure(POL_WORST, 5'd4);
        load_entry(4'd2, 16'd200);
        send_request(16'd100, 1'b0);
        configure(POL_RESERVED, 5'd4);
        load_entry(4'd1, 16'd500);
        send_request(16'd250, 1'b1);
    endtask

    task automatic test_size_extremes();
        configure(POL_FIRST, 5'd2);
        load_entry(4'd0, 16'hFFFF);
        load_entry(4'd1, 16'd0);
        send_request(16'hFFFF, 1'b0);
        send_request(16'd0, 1'b0);
        send_request(16'd0, 1'b0);
        send_request(16'd1, 1'b1);
        send_request(16'd0, 1'b0);
    endtask

    task automatic test_random_traffic(input int n_items);
        int                 sent;
        int                 sel;
        int                 limit;
        int                 batch_len;
        logic               last;
        policy_t            pol;
        logic [COUNT_W-1:0] cnt;
        sent = 0;
        while (sent < n_items) begin
            if (sent == 0 || $urandom_range(0, 2) != 0) begin
                sel = $urandom_range(0, 9);
                case (sel)
                    0:       cnt = '0;
                    1:       cnt = COUNT_W'(NUM_ENTRIES);
                    2:       cnt = '1;
                    3:       cnt = COUNT_W'($urandom_range(NUM_ENTRIES + 1, 30));
                    default: cnt = COUNT_W'($urandom_range(1, NUM_ENTRIES - 1));
                endcase
                pol = policy_t'($urandom_range(0, 3));
                configure(pol, cnt);
            end
            // refresh the scanned entries so a batch has space to hand out
            limit = (cur_count > NUM_ENTRIES) ? NUM_ENTRIES : cur_count;
            for (int j = 0; j < limit; j++) begin
                if (!entry_loaded[j] || $urandom_range(0, 4) != 0) begin
                    load_entry(INDEX_W'(j), random_size(), $urandom_range(0, 7) == 0);
                    sent++;
                end
            end
            batch_len = $urandom_range(1, 10);
            for (int k = 0; k < batch_len; k++) begin
                if ($urandom_range(0, 6) == 0) begin
                    load_entry(INDEX_W'($urandom_range(0, 15)), random_size(),
                               1'($urandom_range(0, 1)));
                    sent++;
                end
                if (k == batch_len - 1)
                    last = ($urandom_range(0, 9) != 0);
                else
                    last = ($urandom_range(0, 19) == 0);
                send_request(random_size(), last);
                sent++;
            end
            if ($urandom_range(0, 5) == 0)
                wait_for_results();
        end
    endtask

    always @(posedge aclk)
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);

    // compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        grant_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_grants.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, got granted %0d index %0d",
                             $time, m_tuser, m_tdata[3:0]);
            end else begin
                want = pending_grants.pop_front();
                check_field("granted", 16'(want.granted), 16'(m_tuser));
                check_field("partition_index", 16'(want.index), 16'(m_tdata[3:0]));
                check_field("space_left_kb", want.left, m_tdata[19:4]);
                check_field("request_number", want.number, m_tdata[35:20]);
                check_field("batch_done", 16'(want.done), 16'(m_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("fixed_partition_fit_allocator_top_tb: errors");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_table();
        test_fit_policies();
        test_size_extremes();

        test_random_traffic(317);
        tx_idle_pct  = 56;
        rx_stall_pct = 26;
        test_random_traffic(317);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        test_random_traffic(316);

        quiesce();
        if (error_count == 0 && pending_grants.size() == 0)
            $display("fixed_partition_fit_allocator_top_tb: clean");
        else
            $display("fixed_partition_fit_allocator_top_tb: errors");
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/fpfa_pkg.sv
hw/rtl/fpfa_ram.sv
hw/rtl/fpfa_scan.sv
hw/rtl/fixed_partition_fit_allocator_top.sv
verif/fixed_partition_fit_allocator_top_tb.sv
